>>> rtl/smallest_fitting_size_lookup_macros.svh
// ----------------------------------------------------------------------------
// smallest_fitting_size_lookup_macros : assertion macros
// Clocked, reset-qualified property checks used by the checker file.
// ----------------------------------------------------------------------------
`ifndef SMALLEST_FITTING_SIZE_LOOKUP_MACROS_SVH
`define SMALLEST_FITTING_SIZE_LOOKUP_MACROS_SVH

// Same-cycle implication: cond |-> expr
`define SFSL_ASSERT_IMPL(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("sfsl assertion failed");

// Next-cycle implication: cond |=> expr
`define SFSL_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("sfsl assertion failed");

`endif

>>> rtl/sfsl_pkg.sv
// ----------------------------------------------------------------------------
// sfsl_pkg
// Widths, opcodes and defaults for the smallest fitting size lookup.
// ----------------------------------------------------------------------------
package sfsl_pkg;

    localparam int OPCODE_W            = 2;
    localparam int VALUE_W             = 16;
    localparam int DEFAULT_MAX_ENTRIES = 64;

    typedef enum logic [OPCODE_W-1:0] {
        OP_CLEAR = 2'd0,
        OP_LOAD  = 2'd1,
        OP_QUERY = 2'd2
    } opcode_t;

endpackage

>>> rtl/sfsl_req_if.sv
// ----------------------------------------------------------------------------
// sfsl_req_if
// Request channel: opcode and value, valid/ready handshake.
// ----------------------------------------------------------------------------
interface sfsl_req_if
    import sfsl_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [VALUE_W-1:0]  value;

    modport source (output valid, output opcode, output value, input ready);
    modport sink   (input valid, input opcode, input value, output ready);
endinterface

>>> rtl/sfsl_rsp_if.sv
// ----------------------------------------------------------------------------
// sfsl_rsp_if
// Result channel: found flag and best capacity, valid/ready handshake.
// ----------------------------------------------------------------------------
interface sfsl_rsp_if
    import sfsl_pkg::*;
;
    logic               valid;
    logic               ready;
    logic               found;
    logic [VALUE_W-1:0] best_capacity;

    modport source (output valid, output found, output best_capacity, input ready);
    modport sink   (input valid, input found, input best_capacity, output ready);
endinterface

>>> rtl/smallest_fitting_size_lookup.sv
// ----------------------------------------------------------------------------
// smallest_fitting_size_lookup
// Capacity table with a lower-bound search over one shared comparator.
// ----------------------------------------------------------------------------
// Usage:
//   req (sink): opcode/value items. Clear empties the table, load appends a
//   capacity (dropped silently when full), query searches the table.
//   rsp (source): one item per query: found and the smallest stored capacity
//   not below the query size (0 when nothing fits).
//   Clear and load are taken with ready staying high.
//   A query over N stored entries reads the table one entry per cycle
//   through a single registered read port and one compare unit: ready is
//   low from the query until the result register is loaded.
//   The result sits in an output register; further clears and loads are
//   taken while it waits. A finished query holds in its last state until
//   the previous result has been taken.
//   Reset empties the table and drops any pending result; table contents
//   are not cleared and need not be.
// ----------------------------------------------------------------------------
module smallest_fitting_size_lookup
    import sfsl_pkg::*;
#(
    parameter int MAX_ENTRIES = DEFAULT_MAX_ENTRIES
) (
    input  logic        clk,
    input  logic        rst_n,
    sfsl_req_if.sink    req,
    sfsl_rsp_if.source  rsp
);

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LAST,
        ST_FINISH
    } state_t;

    logic [VALUE_W-1:0] mem [MAX_ENTRIES];

    state_t             state_reg,    state_next;
    logic [CNT_W-1:0]   count_reg,    count_next;
    logic [IDX_W-1:0]   rd_idx_reg,   rd_idx_next;
    logic [VALUE_W-1:0] query_reg,    query_next;
    logic               cmp_vld_reg,  cmp_vld_next;
    logic               hit_reg,      hit_next;
    logic [VALUE_W-1:0] best_reg,     best_next;
    logic               out_vld_reg,  out_vld_next;
    logic               out_fnd_reg,  out_fnd_next;
    logic [VALUE_W-1:0] out_best_reg, out_best_next;
    logic [VALUE_W-1:0] rd_data_reg;

    logic req_fire;
    logic wr_en;
    logic take;
    logic out_free;
    logic last_idx;

    assign req.ready         = (state_reg == ST_IDLE);
    assign req_fire          = req.valid && req.ready;
    assign rsp.valid         = out_vld_reg;
    assign rsp.found         = out_fnd_reg;
    assign rsp.best_capacity = out_best_reg;

    assign out_free = !out_vld_reg || rsp.ready;
    assign last_idx = (CNT_W'(rd_idx_reg) == (count_reg - CNT_W'(1)));
    assign wr_en    = req_fire && (req.opcode == OP_LOAD)
                      && (count_reg < CNT_W'(MAX_ENTRIES));

    // shared compare unit: fits the query and beats the running minimum
    assign take = cmp_vld_reg && (rd_data_reg >= query_reg)
                  && (!hit_reg || (rd_data_reg < best_reg));

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        rd_idx_next   = rd_idx_reg;
        query_next    = query_reg;
        cmp_vld_next  = 1'b0;
        hit_next      = hit_reg;
        best_next     = best_reg;
        out_vld_next  = out_vld_reg;
        out_fnd_next  = out_fnd_reg;
        out_best_next = out_best_reg;

        if (out_vld_reg && rsp.ready)
        begin
            out_vld_next = 1'b0;
        end

        if (take)
        begin
            hit_next  = 1'b1;
            best_next = rd_data_reg;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    case (req.opcode)
                        OP_CLEAR:
                        begin
                            count_next = '0;
                        end
                        OP_LOAD:
                        begin
                            if (wr_en)
                            begin
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        OP_QUERY:
                        begin
                            query_next  = req.value;
                            hit_next    = 1'b0;
                            best_next   = '0;
                            rd_idx_next = '0;
                            state_next  = (count_reg == '0) ? ST_FINISH : ST_SCAN;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                cmp_vld_next = 1'b1;
                if (last_idx)
                begin
                    state_next = ST_LAST;
                end
                else
                begin
                    rd_idx_next = rd_idx_reg + IDX_W'(1);
                end
            end
            ST_LAST:
            begin
                // last read data is compared this cycle
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_vld_next  = 1'b1;
                    out_fnd_next  = hit_reg;
                    out_best_next = hit_reg ? best_reg : '0;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            cmp_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            cmp_vld_reg <= cmp_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg   <= rd_idx_next;
        query_reg    <= query_next;
        hit_reg      <= hit_next;
        best_reg     <= best_next;
        out_fnd_reg  <= out_fnd_next;
        out_best_reg <= out_best_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[count_reg[IDX_W-1:0]] <= req.value;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_idx_reg];
    end

endmodule

>>> rtl/sfsl_checker.sv
// ----------------------------------------------------------------------------
// sfsl_checker
// Port-level checks for the smallest fitting size lookup, bound to the top.
// ----------------------------------------------------------------------------
`include "smallest_fitting_size_lookup_macros.svh"

module sfsl_checker
    import sfsl_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_ready,
    input logic [OPCODE_W-1:0] req_opcode,
    input logic                rsp_valid,
    input logic                rsp_ready,
    input logic                rsp_found,
    input logic [VALUE_W-1:0]  rsp_best_capacity
);

    logic query_fire;
    logic rsp_stall;

    assign query_fire = req_valid && req_ready && (req_opcode == OP_QUERY);
    assign rsp_stall  = rsp_valid && !rsp_ready;

    `SFSL_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_stall, rsp_valid)
    `SFSL_ASSERT_NEXT(a_rsp_stable, clk, rst_n, rsp_stall, $stable(rsp_best_capacity) && $stable(rsp_found))
    `SFSL_ASSERT_IMPL(a_miss_zero, clk, rst_n, rsp_valid && !rsp_found, rsp_best_capacity == '0)
    `SFSL_ASSERT_NEXT(a_query_busy, clk, rst_n, query_fire, !req_ready)

endmodule

bind smallest_fitting_size_lookup sfsl_checker u_sfsl_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .req_valid         (req.valid),
    .req_ready         (req.ready),
    .req_opcode        (req.opcode),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .rsp_found         (rsp.found),
    .rsp_best_capacity (rsp.best_capacity)
);
